>>> src/idp_pkg.sv
// Shared types and constants for the ISO 8601 date/time parser.
package idp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int FRAC_KEEP   = 6;

  // parse_mode codes
  localparam logic [1:0] MODE_DATE     = 2'd0;
  localparam logic [1:0] MODE_TIME     = 2'd1;
  localparam logic [1:0] MODE_DATETIME = 2'd2;

  // character classes seen by the parser
  typedef enum logic [2:0] {
    CC_OTHER,
    CC_DIGIT,
    CC_PLUS,
    CC_MINUS,
    CC_COLON,
    CC_POINT,
    CC_SEP
  } char_cls_t;

  typedef struct packed {
    char_cls_t   cls;
    logic [3:0]  digit;
    logic        last;
  } item_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [19:0]        microsecond;
  } result_t;

endpackage

>>> src/iso8601_datetime_parser_unit.sv
// Top level of the ISO 8601 date/time parser: mode register and channel wiring.
//
// Feed the timestamp text one character per item on the in_ channel and mark
// the final character with in_tlast. For each string one result item leaves
// on the out_ channel: out_tuser is the valid flag, out_tdata the fields.
// parse_mode is written through cfg_wr_en/cfg_wr_data between strings:
// 0 date only, 1 time only, 2 (or 3) date, separator 'T' or space, time.
//
// Throughput: one character per cycle while no held result stalls a string's
// last character, set by the parser that advances its grammar state once per queued item.
// The last character passes the input register, the queue, then the parser
// with its result register, which raises out_tvalid.
// A stalled out_tready holds the result; characters keep flowing into the
// queue until a second string's last character reaches the parser, and then
// the queue fills and in_tready drops.
// Reset clears the pipeline, empties the queue and sets parse_mode to 2.
module iso8601_datetime_parser_unit
  import idp_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_in
  input  logic        in_tlast,    // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [14:0] year, [18:15] month, [23:19] day,
                                   // [28:24] hour, [34:29] minute,
                                   // [40:35] second, [60:41] microsecond
  output logic        out_tuser,   // valid_res
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data  // parse_mode
);

  logic [1:0] mode_r;
  logic       push;
  logic       push_rdy;
  item_t      front_item;
  logic       q_vld;
  logic       q_pop;
  item_t      q_item;
  result_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DATETIME;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  idp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld_i   (in_tvalid),
    .in_rdy_o   (in_tready),
    .char_i     (in_tdata),
    .last_i     (in_tlast),
    .push_o     (push),
    .push_rdy_i (push_rdy),
    .item_o     (front_item)
  );

  idp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_rdy_o (push_rdy),
    .item_i     (front_item),
    .pop_vld_o  (q_vld),
    .pop_i      (q_pop),
    .item_o     (q_item)
  );

  idp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode_i     (mode_r),
    .item_vld_i (q_vld),
    .item_i     (q_item),
    .pop_o      (q_pop),
    .out_vld_o  (out_tvalid),
    .out_rdy_i  (out_tready),
    .res_o      (res)
  );

  assign out_tuser = res.valid_res;
  assign out_tdata = {3'b000, res.microsecond, res.second, res.minute, res.hour,
                      res.day, res.month, res.year};

endmodule

>>> src/idp_front.sv
// Input stage: accepts characters and registers their class and digit value.
module idp_front
  import idp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld_i,
  output logic       in_rdy_o,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output logic       push_o,
  input  logic       push_rdy_i,
  output item_t      item_o
);

  logic      vld_r;
  item_t     item_r;
  item_t     item_nxt;
  logic      take;

  always_comb begin
    item_nxt.last  = last_i;
    item_nxt.digit = 4'(char_i - 8'h30);
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      item_nxt.cls = CC_DIGIT;
    end else if (char_i == 8'h2B) begin
      item_nxt.cls = CC_PLUS;
    end else if (char_i == 8'h2D) begin
      item_nxt.cls = CC_MINUS;
    end else if (char_i == 8'h3A) begin
      item_nxt.cls = CC_COLON;
    end else if (char_i == 8'h2E || char_i == 8'h2C) begin
      item_nxt.cls = CC_POINT;
    end else if (char_i == 8'h54 || char_i == 8'h20) begin
      item_nxt.cls = CC_SEP;
    end else begin
      item_nxt.cls = CC_OTHER;
    end
  end

  assign push_o   = vld_r && push_rdy_i;
  assign in_rdy_o = !vld_r || push_rdy_i;
  assign take     = in_vld_i && in_rdy_o;
  assign item_o   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push_o) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> src/idp_fifo.sv
// Short queue of classified items between the input stage and the parser.
module idp_fifo
  import idp_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_i,
  output logic  push_rdy_o,
  input  item_t item_i,
  output logic  pop_vld_o,
  input  logic  pop_i,
  output item_t item_o
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  item_t          mem_r [Depth];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic [PW-1:0]  wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_nxt;

  assign push_rdy_o = cnt_r != CW'(Depth);
  assign pop_vld_o  = cnt_r != '0;
  assign item_o     = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(Depth - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
  assign rd_ptr_nxt = (rd_ptr_r == PW'(Depth - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop_i) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push_i && !pop_i) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(Depth))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && cnt_r == CW'(Depth)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop_i && cnt_r == '0))
    else $error("pop from empty queue");

endmodule

>>> src/idp_back.sv
// Parser: walks the grammar one item per cycle, bar a stalled last item; holds result.
module idp_back
  import idp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] mode_i,
  input  logic       item_vld_i,
  input  item_t      item_i,
  output logic       pop_o,
  output logic       out_vld_o,
  input  logic       out_rdy_i,
  output result_t    res_o
);

  typedef enum logic [4:0] {
    PH_START,
    PH_YSIGN,
    PH_YDIG,
    PH_AFTERY,
    PH_MON,
    PH_DSEP,
    PH_DAY,
    PH_AFTERD,
    PH_HOUR,
    PH_AFTERH,
    PH_MIN,
    PH_TSEP,
    PH_SEC,
    PH_AFTERS,
    PH_FRAC0,
    PH_FRAC,
    PH_DEAD
  } phase_t;

  function automatic logic [6:0] acc2(logic [6:0] a, logic [3:0] d);
    logic [10:0] t;
    t = {4'b0, a} * 11'd10 + {7'b0, d};
    return t[6:0];
  endfunction

  function automatic logic [13:0] acc4(logic [13:0] a, logic [3:0] d);
    logic [17:0] t;
    t = {4'b0, a} * 18'd10 + {14'b0, d};
    return t[13:0];
  endfunction

  // value of one fraction digit at its position, already padded to microseconds
  function automatic logic [19:0] frac_weight(logic [2:0] pos, logic [3:0] d);
    logic [19:0] w;
    logic [23:0] p;
    unique case (pos)
      3'd0:    w = 20'd100000;
      3'd1:    w = 20'd10000;
      3'd2:    w = 20'd1000;
      3'd3:    w = 20'd100;
      3'd4:    w = 20'd10;
      3'd5:    w = 20'd1;
      default: w = 20'd0;
    endcase
    p = {4'b0, w} * {20'b0, d};
    return p[19:0];
  endfunction

  phase_t       phase_r, phase_nxt, ph;
  logic         ext_date_r, ext_date_nxt;
  logic         ext_time_r, ext_time_nxt;
  logic [2:0]   dpos_r, dpos_nxt, dpos_inc;
  logic [13:0]  year_r, year_nxt;
  logic         yneg_r, yneg_nxt;
  logic [6:0]   mon_r, mon_nxt;
  logic [6:0]   day_r, day_nxt;
  logic [6:0]   hour_r, hour_nxt;
  logic [6:0]   min_r, min_nxt;
  logic [6:0]   sec_r, sec_nxt;
  logic [19:0]  frac_r, frac_nxt;
  logic [2:0]   fdig_r, fdig_nxt;
  logic [31:0]  sig_r, sig_nxt;
  logic [35:0]  sig_ext;
  logic [6:0]   two;
  logic         two_done;
  logic         isdig;
  logic [3:0]   dig;
  logic         bad;
  logic         ok;
  logic         fin;
  logic         out_vld_r;
  result_t      res_r, res_nxt;

  assign isdig    = item_i.cls == CC_DIGIT;
  assign dig      = item_i.digit;
  assign dpos_inc = 3'(dpos_r + 3'd1);
  assign two_done = dpos_inc >= 3'd2;
  assign sig_ext  = ({4'b0, sig_r} << 3) + ({4'b0, sig_r} << 1) + {32'b0, dig};

  assign pop_o     = item_vld_i && (!item_i.last || !out_vld_r || out_rdy_i);
  assign fin       = pop_o && item_i.last;
  assign out_vld_o = out_vld_r;
  assign res_o     = res_r;

  always_comb begin
    phase_nxt    = phase_r;
    ext_date_nxt = ext_date_r;
    ext_time_nxt = ext_time_r;
    dpos_nxt     = dpos_r;
    year_nxt     = year_r;
    yneg_nxt     = yneg_r;
    mon_nxt      = mon_r;
    day_nxt      = day_r;
    hour_nxt     = hour_r;
    min_nxt      = min_r;
    sec_nxt      = sec_r;
    frac_nxt     = frac_r;
    fdig_nxt     = fdig_r;
    sig_nxt      = sig_r;
    bad          = 1'b0;
    two          = 7'd0;

    // the first item of a string picks the first field
    if (phase_r == PH_START) begin
      ph = (mode_i == MODE_TIME) ? PH_HOUR : PH_YSIGN;
    end else begin
      ph = phase_r;
    end
    phase_nxt = ph;

    unique case (ph)
      PH_YSIGN: begin
        if (item_i.cls == CC_PLUS) begin
          phase_nxt = PH_YDIG;
        end else if (item_i.cls == CC_MINUS) begin
          yneg_nxt  = 1'b1;
          phase_nxt = PH_YDIG;
        end else if (isdig) begin
          year_nxt  = {10'b0, dig};
          dpos_nxt  = 3'd1;
          phase_nxt = PH_YDIG;
        end else begin
          bad = 1'b1;
        end
      end
      PH_YDIG: begin
        if (!isdig) begin
          bad = 1'b1;
        end else begin
          year_nxt = acc4(year_r, dig);
          if (dpos_inc >= 3'd4) begin
            dpos_nxt  = 3'd0;
            phase_nxt = PH_AFTERY;
          end else begin
            dpos_nxt = dpos_inc;
          end
        end
      end
      PH_AFTERY: begin
        if (item_i.cls == CC_MINUS) begin
          ext_date_nxt = 1'b1;
          phase_nxt    = PH_MON;
        end else if (isdig) begin
          mon_nxt   = {3'b0, dig};
          dpos_nxt  = 3'd1;
          phase_nxt = PH_MON;
        end else begin
          bad = 1'b1;
        end
      end
      PH_MON: begin
        if (!isdig) begin
          bad = 1'b1;
        end else begin
          two      = acc2(mon_r, dig);
          mon_nxt  = two;
          dpos_nxt = two_done ? 3'd0 : dpos_inc;
          if (two_done) begin
            bad       = (two < 7'd1) || (two > 7'd12);
            phase_nxt = ext_date_r ? PH_DSEP : PH_DAY;
          end
        end
      end
      PH_DSEP: begin
        if (item_i.cls == CC_MINUS) begin
          phase_nxt = PH_DAY;
        end else begin
          bad = 1'b1;
        end
      end
      PH_DAY: begin
        if (!isdig) begin
          bad = 1'b1;
        end else begin
          two      = acc2(day_r, dig);
          day_nxt  = two;
          dpos_nxt = two_done ? 3'd0 : dpos_inc;
          if (two_done) begin
            bad       = (two < 7'd1) || (two > 7'd31);
            phase_nxt = PH_AFTERD;
          end
        end
      end
      PH_AFTERD: begin
        if (mode_i != MODE_DATE && item_i.cls == CC_SEP) begin
          dpos_nxt  = 3'd0;
          phase_nxt = PH_HOUR;
        end else begin
          bad = 1'b1;
        end
      end
      PH_HOUR: begin
        if (!isdig) begin
          bad = 1'b1;
        end else begin
          two      = acc2(hour_r, dig);
          hour_nxt = two;
          dpos_nxt = two_done ? 3'd0 : dpos_inc;
          if (two_done) begin
            bad       = two > 7'd24;
            phase_nxt = PH_AFTERH;
          end
        end
      end
      PH_AFTERH: begin
        if (item_i.cls == CC_COLON) begin
          ext_time_nxt = 1'b1;
          phase_nxt    = PH_MIN;
        end else if (isdig) begin
          min_nxt   = {3'b0, dig};
          dpos_nxt  = 3'd1;
          phase_nxt = PH_MIN;
        end else begin
          bad = 1'b1;
        end
      end
      PH_MIN: begin
        if (!isdig) begin
          bad = 1'b1;
        end else begin
          two      = acc2(min_r, dig);
          min_nxt  = two;
          dpos_nxt = two_done ? 3'd0 : dpos_inc;
          if (two_done) begin
            bad       = two > 7'd59;
            phase_nxt = ext_time_r ? PH_TSEP : PH_SEC;
          end
        end
      end
      PH_TSEP: begin
        if (item_i.cls == CC_COLON) begin
          phase_nxt = PH_SEC;
        end else begin
          bad = 1'b1;
        end
      end
      PH_SEC: begin
        if (!isdig) begin
          bad = 1'b1;
        end else begin
          two      = acc2(sec_r, dig);
          sec_nxt  = two;
          dpos_nxt = two_done ? 3'd0 : dpos_inc;
          if (two_done) begin
            bad       = two > 7'd60;
            phase_nxt = PH_AFTERS;
          end
        end
      end
      PH_AFTERS: begin
        if (item_i.cls == CC_POINT) begin
          phase_nxt = PH_FRAC0;
        end else begin
          bad = 1'b1;
        end
      end
      PH_FRAC0, PH_FRAC: begin
        if (!isdig) begin
          bad = 1'b1;
        end else begin
          // keep six digits, drop the rest but still range-check the value
          if (fdig_r < 3'(FRAC_KEEP)) begin
            frac_nxt = frac_r + frac_weight(fdig_r, dig);
            fdig_nxt = 3'(fdig_r + 3'd1);
          end
          sig_nxt   = sig_ext[31:0];
          bad       = sig_ext[35:32] != 4'd0;
          phase_nxt = PH_FRAC;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    if (bad) begin
      phase_nxt = PH_DEAD;
    end

    if (mode_i == MODE_DATE) begin
      ok = phase_nxt == PH_AFTERD;
    end else begin
      ok = (phase_nxt == PH_AFTERS) || (phase_nxt == PH_FRAC);
    end

    if (ok) begin
      res_nxt.valid_res   = 1'b1;
      res_nxt.year        = yneg_nxt ? 15'(-{1'b0, year_nxt}) : {1'b0, year_nxt};
      res_nxt.month       = mon_nxt[3:0];
      res_nxt.day         = day_nxt[4:0];
      res_nxt.hour        = hour_nxt[4:0];
      res_nxt.minute      = min_nxt[5:0];
      res_nxt.second      = sec_nxt[5:0];
      res_nxt.microsecond = frac_nxt;
    end else begin
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      ext_date_r <= 1'b0;
      ext_time_r <= 1'b0;
      dpos_r     <= '0;
      year_r     <= '0;
      yneg_r     <= 1'b0;
      mon_r      <= '0;
      day_r      <= '0;
      hour_r     <= '0;
      min_r      <= '0;
      sec_r      <= '0;
      frac_r     <= '0;
      fdig_r     <= '0;
      sig_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_vld_r && out_rdy_i && !fin) begin
        out_vld_r <= 1'b0;
      end
      if (fin) begin
        // string done: hold the result, clear for the next string
        out_vld_r  <= 1'b1;
        res_r      <= res_nxt;
        phase_r    <= PH_START;
        ext_date_r <= 1'b0;
        ext_time_r <= 1'b0;
        dpos_r     <= '0;
        year_r     <= '0;
        yneg_r     <= 1'b0;
        mon_r      <= '0;
        day_r      <= '0;
        hour_r     <= '0;
        min_r      <= '0;
        sec_r      <= '0;
        frac_r     <= '0;
        fdig_r     <= '0;
        sig_r      <= '0;
      end else if (pop_o) begin
        phase_r    <= phase_nxt;
        ext_date_r <= ext_date_nxt;
        ext_time_r <= ext_time_nxt;
        dpos_r     <= dpos_nxt;
        year_r     <= year_nxt;
        yneg_r     <= yneg_nxt;
        mon_r      <= mon_nxt;
        day_r      <= day_nxt;
        hour_r     <= hour_nxt;
        min_r      <= min_nxt;
        sec_r      <= sec_nxt;
        frac_r     <= frac_nxt;
        fdig_r     <= fdig_nxt;
        sig_r      <= sig_nxt;
      end
    end
  end

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(fin))
    else $error("result raised without a last item");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> phase_r == PH_START)
    else $error("parser not restarted after last item");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.valid_res |-> res_r == '0)
    else $error("invalid result carries nonzero fields");

endmodule
